### rtl/lfsq_pkg.sv
// ----------------------------------------------------------------------------
// Largest free square - shared definitions
// Sizes, register indexes, configuration and queue entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsq_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COUNT_LIMIT = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int CNT_W       = COL_W + 1;
	localparam int ROW_IDX_W   = $clog2(COUNT_LIMIT);
	localparam int ROW_CNT_W   = ROW_IDX_W + 1;
	localparam int GEOM_W      = 11;
	localparam int SIZE_W      = 11;
	localparam int CHAR_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CHAR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_CHAR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd4;

	typedef struct packed {
		logic [CHAR_W-1:0] empty_char;
		logic [CHAR_W-1:0] obstacle_char;
		logic [CHAR_W-1:0] full_char;
		logic [GEOM_W-1:0] row_width;
		logic [GEOM_W-1:0] row_count;
	} cfg_t;

	// one classified cell, front to back
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             free;
		logic             bad;
		logic             first;
		logic             frame_err;
		logic             row_end;
		logic             frame_end;
	} q_entry_t;

endpackage

`default_nettype wire

### rtl/lfsq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module lfsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/lfsq_front.sv
// ----------------------------------------------------------------------------
// Largest free square - front end
// Classifies each character and tracks raster position and frame error.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsq_front
	import lfsq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] cell_char
	input  wire logic              q_full,
	output logic                   q_push,
	output q_entry_t               q_wdata
);

	logic [COL_W-1:0]     col_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic                 err_q;

	logic [CNT_W-1:0]     used_w;
	logic [ROW_CNT_W-1:0] used_h;
	logic                 is_obst;
	logic                 is_bad;
	logic                 row_end;
	logic                 frame_end;

	always_comb begin
		if (cfg.row_width == '0) begin
			used_w = CNT_W'(1);
		end else if (cfg.row_width > GEOM_W'(MAX_WIDTH)) begin
			used_w = CNT_W'(MAX_WIDTH);
		end else begin
			used_w = CNT_W'(cfg.row_width);
		end
		if (cfg.row_count == '0) begin
			used_h = ROW_CNT_W'(1);
		end else if (cfg.row_count > GEOM_W'(COUNT_LIMIT)) begin
			used_h = ROW_CNT_W'(COUNT_LIMIT);
		end else begin
			used_h = ROW_CNT_W'(cfg.row_count);
		end
	end

	// obstacle code wins over the other two
	assign is_obst   = (s_tdata == cfg.obstacle_char);
	assign is_bad    = !is_obst && (s_tdata != cfg.empty_char) && (s_tdata != cfg.full_char);
	assign row_end   = (CNT_W'(col_q) + CNT_W'(1)) >= used_w;
	assign frame_end = row_end && ((ROW_CNT_W'(row_q) + ROW_CNT_W'(1)) >= used_h);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_wdata.col       = col_q;
		q_wdata.free      = !is_obst && !is_bad;
		q_wdata.bad       = is_bad;
		q_wdata.first     = (col_q == '0) || (row_q == '0);
		q_wdata.frame_err = err_q || is_bad;
		q_wdata.row_end   = row_end;
		q_wdata.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			err_q <= 1'b0;
		end else if (q_push) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
					err_q <= 1'b0;
				end else begin
					row_q <= row_q + ROW_IDX_W'(1);
					err_q <= err_q || is_bad;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				err_q <= err_q || is_bad;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lfsq_queue.sv
// ----------------------------------------------------------------------------
// Largest free square - decoupling queue
// Small flop FIFO between the front end and the size pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsq_queue
	import lfsq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wdata,
	output logic          full,
	input  wire logic     pop,
	output logic          valid,
	output q_entry_t      head
);

	q_entry_t            ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QPTR_W:0]     count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lfsq_back.sv
// ----------------------------------------------------------------------------
// Largest free square - size pipeline
// Line buffer read, min-of-three update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsq_back
	import lfsq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire q_entry_t          q_head,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [15:0]       m_tdata,   // [10:0] square_size, rest zero
	output logic      [2:0]        m_tuser,   // [0] bad_char [1] frame_error [2] last_in_row
	output logic                   m_tlast    // last_in_frame
);

	logic                adv;
	logic                s1_valid_s1;
	q_entry_t            ent_s1;
	logic                fwd_s1;
	logic [SIZE_W-1:0]   fwd_size_s1;
	logic [SIZE_W-1:0]   rd_up;
	logic [SIZE_W-1:0]   up;
	logic [SIZE_W-1:0]   min_lu;
	logic [SIZE_W-1:0]   min3;
	logic [SIZE_W-1:0]   size;
	logic                wr_en;
	logic [SIZE_W-1:0]   left_q;
	logic [SIZE_W-1:0]   upleft_q;
	logic                out_valid_q;
	logic [SIZE_W-1:0]   out_size_q;
	logic [2:0]          out_user_q;
	logic                out_last_q;

	assign adv   = !out_valid_q || m_tready;
	assign q_pop = adv && q_valid;
	assign wr_en = adv && s1_valid_s1;

	lfsq_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ent_s1.col),
		.wdata(size),
		.re   (q_pop),
		.raddr(q_head.col),
		.rdata(rd_up)
	);

	// a one-cell row reads the slot being written in the same cycle
	assign up     = fwd_s1 ? fwd_size_s1 : rd_up;
	assign min_lu = (left_q < up) ? left_q : up;
	assign min3   = (min_lu < upleft_q) ? min_lu : upleft_q;

	always_comb begin
		if (!ent_s1.free) begin
			size = '0;
		end else if (ent_s1.first) begin
			size = SIZE_W'(1);
		end else begin
			size = min3 + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_s1      <= q_head;
			fwd_size_s1 <= size;
		end
		if (wr_en) begin
			out_size_q <= size;
			out_user_q <= {ent_s1.row_end, ent_s1.frame_err, ent_s1.bad};
			out_last_q <= ent_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			upleft_q    <= '0;
		end else if (adv) begin
			s1_valid_s1 <= q_valid;
			fwd_s1      <= q_pop && s1_valid_s1 && (q_head.col == ent_s1.col);
			out_valid_q <= s1_valid_s1;
			if (s1_valid_s1) begin
				left_q   <= ent_s1.row_end ? '0 : size;
				upleft_q <= ent_s1.row_end ? '0 : up;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16-SIZE_W){1'b0}}, out_size_q};
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

### rtl/largest_free_square_dp.sv
// Path: a cell accepted into the queue passes the size stage and the output register.
// Throughput: one cell per cycle unless m_tready stalls the output; the line buffer read
// feeds the min-of-three update, and the input stalls only once the queue holds four cells.
// Reset: asynchronous, clears positions, error flag, queue and pipeline valids and
// restores the default codes and geometry; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// Largest free square - top level
// Configuration registers, front end, queue and size pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_free_square_dp
	import lfsq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GEOM_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] cell_char
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [15:0]          m_tdata,   // [10:0] square_size, [15:11] zero
	output logic      [2:0]           m_tuser,   // [0] bad_char [1] frame_error [2] last_in_row
	output logic                      m_tlast    // last_in_frame
);

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	q_entry_t q_wdata;
	logic     q_pop;
	logic     q_valid;
	q_entry_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.empty_char    <= CHAR_W'(46);
			cfg_q.obstacle_char <= CHAR_W'(111);
			cfg_q.full_char     <= CHAR_W'(120);
			cfg_q.row_width     <= GEOM_W'(1024);
			cfg_q.row_count     <= GEOM_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EMPTY_CHAR:    cfg_q.empty_char    <= cfg_data[CHAR_W-1:0];
				REG_OBSTACLE_CHAR: cfg_q.obstacle_char <= cfg_data[CHAR_W-1:0];
				REG_FULL_CHAR:     cfg_q.full_char     <= cfg_data[CHAR_W-1:0];
				REG_ROW_WIDTH:     cfg_q.row_width     <= cfg_data;
				REG_ROW_COUNT:     cfg_q.row_count     <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	lfsq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	lfsq_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.head  (q_head)
	);

	lfsq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// a stalled input side always has queued work to drain
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with empty queue");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[10:0] == 11'd0))
		else $error("bad character gave non-zero size");

	a_bad_sets_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("bad character without frame error");

	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[2])
		else $error("frame end not on a row end");

endmodule

`default_nettype wire
